### rtl/sliding_window_maximum_defines.svh
// ----------------------------------------------------------------------------
// Sliding window maximum: assertion macros
// Clocked assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MAXIMUM_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sliding_window_maximum: assertion failed");
// Condition must never be true outside reset
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `SWM_ASSERT(lbl, clk, rst_n, !(cond))
`else
`define SWM_ASSERT(lbl, clk, rst_n, prop)
`define SWM_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

### rtl/swm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: package
// Shared widths, types, register codes and a helper function.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int WindowMax  = 256;
  localparam int SampleBits = 16;
  localparam int PtrBits    = $clog2(WindowMax);
  localparam int PosBits    = PtrBits + 1;          // positions modulo 2*WindowMax
  localparam int CntBits    = $clog2(WindowMax + 1);
  localparam int WinBits    = 9;                    // window_size register width
  localparam int CmpBits    = (SampleBits > PosBits) ? SampleBits : PosBits;
  localparam int AddrBits   = 3;
  localparam int DataBits   = 32;

  // Register index codes (byte address 4*i)
  localparam logic RegWindowSize = 1'b0;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StFront,
    StBack,
    StResult
  } state_e;

  // Operating mode of the shared comparator
  typedef enum logic {
    CmpAge,
    CmpValue
  } cmp_mode_e;

  // One deque entry
  typedef struct packed {
    logic [PosBits-1:0]           pos;
    logic signed [SampleBits-1:0] value;
  } entry_t;

  // Access request to the deque store
  typedef struct packed {
    logic               we;
    logic [PtrBits-1:0] waddr;
    entry_t             wdata;
    logic [PtrBits-1:0] raddr;
  } store_req_t;

  // Window size as used: zero means one, above the store depth saturates
  function automatic logic [CntBits-1:0] eff_window(input logic [WinBits-1:0] ws);
    logic [CntBits-1:0] k;
    if (ws == '0) begin
      k = CntBits'(1);
    end else if (32'(ws) > WindowMax) begin
      k = CntBits'(WindowMax);
    end else begin
      k = CntBits'(ws);
    end
    return k;
  endfunction

endpackage

### rtl/swm_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: deque store
// Ring of entries, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module swm_store (
  input  logic                clk_i,
  input  swm_pkg::store_req_t req_i,
  output swm_pkg::entry_t     rdata_o
);
  import swm_pkg::*;

  entry_t mem [WindowMax];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port (returns old data on a same-address write)
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swm_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: shared comparator
// One unsigned compare, used for front age checks and back value checks.
// ----------------------------------------------------------------------------
module swm_cmp (
  input  swm_pkg::cmp_mode_e              mode_i,
  input  logic [swm_pkg::PosBits-1:0]     cur_pos_i,
  input  logic [swm_pkg::CntBits-1:0]     window_i,
  input  logic signed [swm_pkg::SampleBits-1:0] sample_i,
  input  swm_pkg::entry_t                 entry_i,
  output logic                            ge_o
);
  import swm_pkg::*;

  localparam logic [SampleBits-1:0] SignBit = {1'b1, {(SampleBits-1){1'b0}}};

  logic [PosBits-1:0] age;
  logic [CmpBits-1:0] opa;
  logic [CmpBits-1:0] opb;

  // Age wraps naturally modulo 2*WindowMax
  assign age = cur_pos_i - entry_i.pos;

  // Operand select: age >= window, or new sample >= back value (offset binary)
  always_comb begin
    case (mode_i)
      CmpAge: begin
        opa = CmpBits'(age);
        opb = CmpBits'(window_i);
      end
      CmpValue: begin
        opa = CmpBits'(sample_i ^ SignBit);
        opb = CmpBits'(entry_i.value ^ SignBit);
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign ge_o = (opa >= opb);

endmodule

### rtl/swm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: sequencer
// Walks the deque one entry a cycle: front expiry, back pops, push, result.
// ----------------------------------------------------------------------------
`include "sliding_window_maximum_defines.svh"

module swm_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [swm_pkg::WinBits-1:0]         window_size_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [swm_pkg::SampleBits-1:0] in_sample_i,
  input  logic                                in_restart_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [swm_pkg::SampleBits-1:0] out_max_o
);
  import swm_pkg::*;

  state_e                       state_q, state_d;
  logic [PtrBits-1:0]           head_q, head_d;
  logic [PtrBits-1:0]           tail_q, tail_d;
  logic [CntBits-1:0]           occ_q, occ_d;
  logic [PosBits-1:0]           pos_q, pos_d;
  logic [CntBits-1:0]           filled_q, filled_d;
  logic signed [SampleBits-1:0] sample_q, sample_d;
  logic                         empty_q, empty_d;
  logic                         has_res_q, has_res_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] out_max_q, out_max_d;

  logic [CntBits-1:0] k;
  store_req_t         req;
  entry_t             rdata;
  cmp_mode_e          cmp_mode;
  logic               cmp_ge;
  logic               accept;
  logic               pop;
  logic               full;
  logic [CntBits-1:0] filled_inc;
  logic               out_free;
  logic signed [SampleBits-1:0] res_value;

  assign k          = eff_window(window_size_i);
  assign accept     = in_valid_i && (state_q == StIdle);
  assign cmp_mode   = (state_q == StBack) ? CmpValue : CmpAge;
  assign pop        = (occ_q != '0) && cmp_ge;
  assign full       = (occ_q == CntBits'(WindowMax));
  assign filled_inc = (filled_q == CntBits'(WindowMax)) ? filled_q : filled_q + 1'b1;
  assign out_free   = !out_valid_q || out_ready_i;
  assign res_value  = empty_q ? sample_q : rdata.value;

  swm_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  swm_cmp u_cmp (
    .mode_i    (cmp_mode),
    .cur_pos_i (pos_q),
    .window_i  (k),
    .sample_i  (sample_q),
    .entry_i   (rdata),
    .ge_o      (cmp_ge)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (accept) state_d = StFront;
      end
      StFront: begin
        if (!pop) state_d = StBack;
      end
      StBack: begin
        if (!pop) state_d = StResult;
      end
      StResult: begin
        if (!has_res_q || out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Datapath and store requests
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    pos_d       = pos_q;
    filled_d    = filled_q;
    sample_d    = sample_q;
    empty_d     = empty_q;
    has_res_d   = has_res_q;
    out_max_d   = out_max_q;
    out_valid_d = out_valid_q && !out_ready_i;
    req         = '0;
    req.raddr   = head_q;
    req.wdata.value = sample_q;
    req.wdata.pos   = pos_q;
    req.waddr       = tail_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          sample_d = in_sample_i;
          if (in_restart_i) begin
            head_d   = '0;
            tail_d   = '0;
            occ_d    = '0;
            pos_d    = '0;
            filled_d = '0;
            req.raddr = '0;
          end
        end
      end
      StFront: begin
        // Expire the front entry, else read the back entry
        if (pop) begin
          head_d    = head_q + 1'b1;
          occ_d     = occ_q - 1'b1;
          req.raddr = head_q + 1'b1;
        end else begin
          req.raddr = tail_q - 1'b1;
        end
      end
      StBack: begin
        if (pop) begin
          // Back entry no greater than the new sample
          tail_d    = tail_q - 1'b1;
          occ_d     = occ_q - 1'b1;
          req.raddr = tail_q - 2'd2;
        end else begin
          // Push; drop the front first if the ring is full
          req.we    = 1'b1;
          head_d    = full ? head_q + 1'b1 : head_q;
          occ_d     = full ? occ_q : occ_q + 1'b1;
          tail_d    = tail_q + 1'b1;
          req.raddr = head_d;
          empty_d   = (occ_q == '0);
          pos_d     = pos_q + 1'b1;
          filled_d  = filled_inc;
          has_res_d = (filled_inc >= k);
        end
      end
      StResult: begin
        if (has_res_q && out_free) begin
          out_valid_d = 1'b1;
          out_max_d   = res_value;
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      pos_q       <= '0;
      filled_q    <= '0;
      empty_q     <= 1'b0;
      has_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      pos_q       <= pos_d;
      filled_q    <= filled_d;
      empty_q     <= empty_d;
      has_res_q   <= has_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    out_max_q <= out_max_d;
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_max_o   = out_max_q;

  // Checks
  `SWM_ASSERT_NEVER(a_occ_range, clk_i, rst_ni, occ_q > CntBits'(WindowMax))
  `SWM_ASSERT(a_ring_consistent, clk_i, rst_ni, (PtrBits'(tail_q - head_q)) == occ_q[PtrBits-1:0])
  `SWM_ASSERT(a_accept_starts, clk_i, rst_ni, accept |=> (state_q == StFront))
  `SWM_ASSERT(a_result_filled, clk_i, rst_ni, (state_q == StResult && has_res_q) |-> (filled_q >= k))
  `SWM_ASSERT(a_push_nonempty, clk_i, rst_ni, (state_q == StResult) |-> (occ_q != '0))

endmodule

### rtl/swm_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: configuration registers
// APB-style register file holding window_size.
// ----------------------------------------------------------------------------
module swm_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::AddrBits-1:0]  paddr,
  input  logic [swm_pkg::DataBits-1:0]  pwdata,
  output logic [swm_pkg::DataBits-1:0]  prdata,
  output logic                          pready,
  output logic [swm_pkg::WinBits-1:0]   window_size_o
);
  import swm_pkg::*;

  logic [WinBits-1:0] window_size_q, window_size_d;
  logic               reg_idx;
  logic               wr;

  assign reg_idx = paddr[2];
  assign wr      = psel && penable && pwrite;

  // Write decode
  always_comb begin
    window_size_d = window_size_q;
    if (wr) begin
      unique case (reg_idx)
        RegWindowSize: window_size_d = pwdata[WinBits-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WinBits'(3);
    end else begin
      window_size_q <= window_size_d;
    end
  end

  // Read decode
  always_comb begin
    unique case (reg_idx)
      RegWindowSize: prdata = DataBits'(window_size_q);
      default:       prdata = '0;
    endcase
  end

  assign pready        = 1'b1;
  assign window_size_o = window_size_q;

endmodule

### rtl/sliding_window_maximum.sv
`timescale 1ns / 1ps
// Sequence: E front expiries and P back pops per input sample, one deque
//   entry per cycle, then the push and the result register (held on output
//   stall); no new sample is taken meanwhile. E + P averages about one.
// Reset: pointers, counts and window_size (3) clear at once; the deque
//   store needs no clearing pass, its entries are only read once written.
// ----------------------------------------------------------------------------
// Sliding window maximum: top level
// Running maximum over the last window_size samples, monotonic deque.
// ----------------------------------------------------------------------------
module sliding_window_maximum (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::AddrBits-1:0]  paddr,
  input  logic [swm_pkg::DataBits-1:0]  pwdata,
  output logic [swm_pkg::DataBits-1:0]  prdata,
  output logic                          pready,
  // Sample stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // [15:0] sample
  input  logic [0:0]                    s_axis_tuser,  // [0] restart
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata   // [15:0] window_max
);
  import swm_pkg::*;

  logic [WinBits-1:0]           window_size;
  logic signed [SampleBits-1:0] out_max;

  swm_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .window_size_o (window_size)
  );

  swm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .window_size_i (window_size),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_sample_i   (s_axis_tdata[SampleBits-1:0]),
    .in_restart_i  (s_axis_tuser[0]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_max_o     (out_max)
  );

  assign m_axis_tdata = 16'(out_max);

endmodule

### bench/swm_window_max_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: stream checker
// Follows the register port and both streams, keeps its own deque in step
// with every accepted sample and compares each result transfer, oldest first,
// against the predicted window maximum. Register reads are checked as well.
// ----------------------------------------------------------------------------
module swm_window_max_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [swm_pkg::AddrBits-1:0]  paddr,
  input  logic [swm_pkg::DataBits-1:0]  pwdata,
  input  logic [swm_pkg::DataBits-1:0]  prdata,
  input  logic                          pready,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,   // [15:0] sample
  input  logic [0:0]                    s_axis_tuser,   // [0] restart
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [15:0]                   m_axis_tdata,   // [15:0] window_max
  output int                            fail_count_o,
  output int                            pending_o
);
  import swm_pkg::*;

  localparam logic [AddrBits-1:0] WinSizeAddr = AddrBits'({RegWindowSize, 2'b00});
  localparam logic [WinBits-1:0]  WinSizeReset = WinBits'(3);

  // Shadow of the block state
  logic signed [SampleBits-1:0] dq_val [WindowMax];
  logic [PosBits-1:0]           dq_pos [WindowMax];
  logic [PtrBits-1:0]           dq_head;
  logic [PtrBits-1:0]           dq_tail;
  int                           dq_count;
  logic [PosBits-1:0]           next_pos;
  int                           filled;
  logic [WinBits-1:0]           win_reg;
  logic signed [SampleBits-1:0] window_max_q [$];
  logic signed [SampleBits-1:0] want;

  // Advance the deque by one sample and queue the maximum it yields, if any
  task automatic track_sample(input logic signed [SampleBits-1:0] smp, input logic restart);
    int                 k;
    logic [PosBits-1:0] age;
    logic [PtrBits-1:0] back;
    bit                 stop;
    k = (win_reg == '0) ? 1 : (int'(win_reg) > WindowMax) ? WindowMax : int'(win_reg);
    if (restart) begin
      dq_head  = '0;
      dq_tail  = '0;
      dq_count = 0;
      next_pos = '0;
      filled   = 0;
    end
    // drop entries that have aged out of the window (positions wrap mod 2*depth)
    stop = 1'b0;
    while (dq_count > 0 && !stop) begin
      age = next_pos - dq_pos[dq_head];
      if (int'(age) < k) begin
        stop = 1'b1;
      end else begin
        dq_head++;
        dq_count--;
      end
    end
    // pop back entries not above the new sample, ties included
    stop = 1'b0;
    while (dq_count > 0 && !stop) begin
      back = dq_tail - 1'b1;
      if (dq_val[back] > smp) begin
        stop = 1'b1;
      end else begin
        dq_tail = back;
        dq_count--;
      end
    end
    if (dq_count >= WindowMax) begin
      dq_head++;
      dq_count--;
    end
    dq_val[dq_tail] = smp;
    dq_pos[dq_tail] = next_pos;
    dq_tail++;
    dq_count++;
    next_pos++;
    if (filled < WindowMax) filled++;
    if (filled >= k) window_max_q.insert(window_max_q.size(), dq_val[dq_head]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_head      = '0;
      dq_tail      = '0;
      dq_count     = 0;
      next_pos     = '0;
      filled       = 0;
      win_reg      = WinSizeReset;
      window_max_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // register port: track writes, check reads
      if (psel && penable && pready && paddr == WinSizeAddr) begin
        if (pwrite) begin
          win_reg = pwdata[WinBits-1:0];
        end else if (prdata !== DataBits'(win_reg)) begin
          $display("%0t: window_size read: expected %0d, actual %0d",
                   $time, win_reg, prdata);
          fail_count_o++;
        end
      end
      // sample transfer
      if (s_axis_tvalid && s_axis_tready) begin
        track_sample($signed(s_axis_tdata), s_axis_tuser[0]);
      end
      // result transfer
      if (m_axis_tvalid && m_axis_tready) begin
        if (window_max_q.size() == 0) begin
          $display("%0t: window_max: expected none, actual %0d",
                   $time, $signed(m_axis_tdata));
          fail_count_o++;
        end else begin
          want = window_max_q[0];
          window_max_q.delete(0);
          if (m_axis_tdata !== want) begin
            $display("%0t: window_max: expected %0d, actual %0d",
                     $time, want, $signed(m_axis_tdata));
            fail_count_o++;
          end
        end
      end
      pending_o = window_max_q.size();
    end
  end

endmodule

### bench/tb_sliding_window_maximum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window maximum: testbench top
// Drives a directed opening at the reset window size, then random sample
// streams under a series of window sizes (zero, one, the store depth and
// beyond, shrinking between phases), with random gaps on both streams and one
// long result stall. The checker does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_sliding_window_maximum;
  import swm_pkg::*;

  localparam logic [AddrBits-1:0] WinSizeAddr = AddrBits'({RegWindowSize, 2'b00});
  localparam int DrainCycles = 600;      // covers the longest expiry plus pop run
  localparam int CycleLimit  = 400000;
  localparam int NumDirected = 20;
  localparam int NumPhases   = 8;
  localparam int LongHoldAt  = 20;       // result count at which the long stall starts
  localparam int LongHold    = 500;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AddrBits-1:0] paddr;
  logic [DataBits-1:0] pwdata;
  logic [DataBits-1:0] prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata;   // [15:0] sample
  logic [0:0]          s_axis_tuser;   // [0] restart
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;   // [15:0] window_max
  int                  fail_count;
  int                  pending;
  int                  cycles = 0;
  bit                  tx_steady;
  bit                  rx_steady;

  // Opening sequence: extremes, ties, a falling run, restarts
  int dir_smp [NumDirected] = '{-32768, 32767, 32767, 0, -1, -1, -1, 5, 4, 3,
                                2, 1, 100, -32768, -32768, 7, 32767, -5, -32768, 0};
  bit dir_rst [NumDirected] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                                0, 0, 1, 0, 0, 0, 1, 0, 0, 0};

  // Window size, sample count and restart odds (percent) per phase
  int phase_win [NumPhases] = '{1, 0, 2, 256, 511, 5, 60, 4};
  int phase_len [NumPhases] = '{40, 40, 60, 270, 50, 60, 90, 40};
  int phase_rst [NumPhases] = '{4, 4, 4, 0, 0, 3, 1, 4};

  sliding_window_maximum dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  swm_window_max_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Register access: setup, access and idle phases; called at a falling edge
  task automatic reg_access(input bit wr, input logic [DataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WinSizeAddr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // One sample transfer; called and returns at a falling edge
  task automatic send_sample(input logic signed [15:0] smp, input logic restart);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk_i);
  endtask

  // Wait until every predicted maximum has come out and the block has gone quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Random sample: a mix of wide random values, ties, extremes and sloped runs
  function automatic logic signed [15:0] draw_sample(input logic signed [15:0] last);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2: v = int'($urandom_range(0, 65535)) - 32768;
      3, 4:    v = int'($urandom_range(0, 8)) - 4;
      5:       v = $urandom_range(0, 1) ? 32767 : -32768;
      6, 7, 8: v = int'(last) - int'($urandom_range(0, 40));
      default: v = int'(last) + int'($urandom_range(0, 40));
    endcase
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return 16'(v);
  endfunction

  // Result side: random stalls, one long hold-off while samples keep coming
  initial begin : result_sink
    int gap;
    int n_rx;
    m_axis_tready = 1'b0;
    rx_steady     = 1'b0;
    n_rx = 0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
      n_rx++;
      if (n_rx % 40 == 0) rx_steady = ($urandom_range(0, 3) == 0);
      gap = rx_steady ? 0 : $urandom_range(0, 5);
      if (n_rx == LongHoldAt) gap = LongHold;
      if (gap > 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    logic signed [15:0] last;
    int                 n_tx;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    tx_steady     = 1'b0;
    last          = '0;
    n_tx          = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed opening at the reset window size
    reg_access(1'b0, '0);
    for (int i = 0; i < NumDirected; i++) begin
      send_sample(16'(dir_smp[i]), dir_rst[i]);
    end

    // random phases; the deque carries over between them unless restarted
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      reg_access(1'b1, DataBits'(phase_win[p]));
      reg_access(1'b0, '0);
      for (int i = 0; i < phase_len[p]; i++) begin
        n_tx++;
        if (n_tx % 50 == 0) tx_steady = ($urandom_range(0, 3) == 0);
        last = draw_sample(last);
        send_sample(last, $urandom_range(0, 99) < phase_rst[p]);
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
